// File: sv/cdsd_pkg.sv
package cdsd_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_WINDOW_DEF = 7;
	localparam int MAX_DISP_DEF = 128;
	localparam int HEIGHT_TOP = 1024;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] WINDOW_RESET = 3'd5;
	localparam logic [7:0] DISP_RESET = 8'd80;
	localparam logic [10:0] WIDTH_RESET = 11'd640;
	localparam logic [10:0] HEIGHT_RESET = 11'd480;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_DISP = 2'd1;
	localparam logic [1:0] REG_WIDTH = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	typedef struct packed {
		logic [2:0] window_size;
		logic [7:0] num_disparities;
		logic [10:0] image_width;
		logic [10:0] image_height;
	} cdsd_cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SHIFT,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SEARCH,
		B_DRAIN,
		B_DIVSET,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

// File: sv/cdsd_in_if.sv
interface cdsd_in_if;
	logic valid;
	logic ready;
	logic [7:0] left_pixel;
	logic [7:0] right_pixel;
	logic frame_start;

	modport source(output valid, output left_pixel, output right_pixel, output frame_start,
		input ready);
	modport sink(input valid, input left_pixel, input right_pixel, input frame_start,
		output ready);
endinterface

// File: sv/cdsd_out_if.sv
interface cdsd_out_if;
	logic valid;
	logic ready;
	logic [9:0] pixel_row;
	logic [9:0] pixel_column;
	logic [6:0] disparity;
	logic [7:0] scaled_disparity;
	logic [5:0] best_cost;
	logic frame_last;

	modport source(output valid, output pixel_row, output pixel_column, output disparity,
		output scaled_disparity, output best_cost, output frame_last, input ready);
	modport sink(input valid, input pixel_row, input pixel_column, input disparity,
		input scaled_disparity, input best_cost, input frame_last, output ready);
endinterface

// File: sv/census_stereo_disparity_top.sv
// Census stereo matcher. Left and right pixels enter as one item per pixel pair in raster
// order; every interior pixel gives one result item with its winning disparity, the scaled
// disparity and the Hamming cost, and border pixels give none. The front end finishes one
// pixel (line memories, window shift, census codes) before it takes the next and hands
// interior pixels through a four-entry queue to the search engine, which tests one
// disparity candidate per cycle on the right-code history memory and then runs an 8-step
// divider for the scaled value, and takes no new pixel until it is done; that loop sets
// the sustained rate. Registers on the APB port: window_size at 0x0, num_disparities at
// 0x4, image_width at 0x8, image_height at 0xC; write them only while the block is idle.
module census_stereo_disparity_top #(
	parameter int MAX_WIDTH = cdsd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW = cdsd_pkg::MAX_WINDOW_DEF,
	parameter int MAX_DISP = cdsd_pkg::MAX_DISP_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	cdsd_in_if.sink pix,
	cdsd_out_if.source res
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int CODE_W = MAX_WINDOW * MAX_WINDOW - 1;
	localparam int EW = 2 * CODE_W + XW + 11;
	localparam logic [2:0] WIN_TOP = 3'((MAX_WINDOW - 1) | 1);
	localparam int DISP_TOP = (MAX_DISP / 16) * 16;

	cdsd_pkg::cdsd_cfg_t cfg_q;
	logic cfg_write;
	logic [2:0] ws_v;
	logic [7:0] nd_v;
	logic [10:0] iw_v, ih_v;

	logic f_valid, f_ready, b_valid, b_ready;
	logic [EW-1:0] f_data, b_data;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		ws_v = pwdata[2:0];
		if (!ws_v[0]) ws_v = ws_v + 3'd1;
		if (ws_v < 3'd3) ws_v = 3'd3;
		if (ws_v > WIN_TOP) ws_v = WIN_TOP;
		nd_v = {pwdata[7:4], 4'b0000};
		if (nd_v < 8'd16) nd_v = 8'd16;
		if (9'(nd_v) > 9'(DISP_TOP)) nd_v = 8'(DISP_TOP);
		iw_v = pwdata[10:0];
		if (iw_v < 11'd8) iw_v = 11'd8;
		if (13'(iw_v) > 13'(MAX_WIDTH)) iw_v = 11'(MAX_WIDTH);
		ih_v = pwdata[10:0];
		if (ih_v < 11'd8) ih_v = 11'd8;
		if (ih_v > 11'(cdsd_pkg::HEIGHT_TOP)) ih_v = 11'(cdsd_pkg::HEIGHT_TOP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size <= cdsd_pkg::WINDOW_RESET;
			cfg_q.num_disparities <= cdsd_pkg::DISP_RESET;
			cfg_q.image_width <= cdsd_pkg::WIDTH_RESET;
			cfg_q.image_height <= cdsd_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			case (paddr[3:2])
				cdsd_pkg::REG_WINDOW: cfg_q.window_size <= ws_v;
				cdsd_pkg::REG_DISP: cfg_q.num_disparities <= nd_v;
				cdsd_pkg::REG_WIDTH: cfg_q.image_width <= iw_v;
				cdsd_pkg::REG_HEIGHT: cfg_q.image_height <= ih_v;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cdsd_pkg::REG_WINDOW: prdata = 32'(cfg_q.window_size);
			cdsd_pkg::REG_DISP: prdata = 32'(cfg_q.num_disparities);
			cdsd_pkg::REG_WIDTH: prdata = 32'(cfg_q.image_width);
			cdsd_pkg::REG_HEIGHT: prdata = 32'(cfg_q.image_height);
			default: prdata = '0;
		endcase
	end

	cdsd_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pix(pix),
		.ent_valid(f_valid),
		.ent_data(f_data),
		.ent_ready(f_ready)
	);

	cdsd_queue #(
		.WIDTH(EW),
		.DEPTH(cdsd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data(f_data),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_data(b_data)
	);

	cdsd_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_WINDOW(MAX_WINDOW),
		.MAX_DISP(MAX_DISP)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.ent_valid(b_valid),
		.ent_ready(b_ready),
		.ent_data(b_data),
		.res(res)
	);

	// The front end needs its shift and census cycles after every accepted item.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> !pix.ready)
		else $error("front end accepted items on consecutive cycles");

	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.disparity == 7'd0) |-> (res.scaled_disparity == 8'd0))
		else $error("scaled disparity nonzero for zero disparity");

	a_odd_window: assert property (@(posedge clk) disable iff (!arst_n)
		(paddr[3:2] == cdsd_pkg::REG_WINDOW) |-> prdata[0])
		else $error("window size register holds an even value");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		b_valid && b_ready |=> !b_ready)
		else $error("search engine took a new item before finishing the last");

endmodule

// File: sv/cdsd_front.sv
module cdsd_front #(
	parameter int MAX_WIDTH = cdsd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW = cdsd_pkg::MAX_WINDOW_DEF,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int CODE_W = MAX_WINDOW * MAX_WINDOW - 1,
	localparam int EW = 2 * CODE_W + XW + 11
) (
	input logic clk,
	input logic arst_n,
	input cdsd_pkg::cdsd_cfg_t cfg,
	cdsd_in_if.sink pix,
	output logic ent_valid,
	output logic [EW-1:0] ent_data,
	input logic ent_ready
);

	localparam int LINES = MAX_WINDOW - 1;
	localparam int SW = $clog2(LINES);
	localparam int TW = (XW + 1 > 11) ? XW + 1 : 11;

	cdsd_pkg::front_state_t state_q, state_d;

	logic [9:0] row_q;
	logic [XW-1:0] col_q;
	logic [SW-1:0] slot_q;

	logic [TW-1:0] width_ext, col_a, col_n;
	logic [10:0] row_a, row_n;
	logic [SW-1:0] slot_a, slot_n;
	logic accept;

	logic [9:0] row_cur_q;
	logic [XW-1:0] col_cur_q;
	logic [SW-1:0] slot_cur_q;
	logic [7:0] lp_q, rp_q;

	logic [7:0] mem_l [LINES][MAX_WIDTH];
	logic [7:0] mem_r [LINES][MAX_WIDTH];
	logic [7:0] rdl_q [LINES];
	logic [7:0] rdr_q [LINES];
	logic [SW-1:0] line_sel [1:LINES];

	logic [7:0] wl_q [MAX_WINDOW][MAX_WINDOW];
	logic [7:0] wr_q [MAX_WINDOW][MAX_WINDOW];

	logic [1:0] half;
	logic [2:0] two_half;
	logic interior, last;
	logic [CODE_W-1:0] lcode, rcode;
	logic [9:0] y_val;
	logic [XW-1:0] x_val;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(LINES - 1)) ? '0 : s + SW'(1);
	endfunction

	// Bit order: MSB is the oldest row and column of the window; the centre has no bit.
	function automatic logic [CODE_W-1:0] census(input logic [7:0] w [MAX_WINDOW][MAX_WINDOW],
			input logic [1:0] h);
		logic [CODE_W-1:0] code;
		int n, pos, ctr;
		code = '0;
		for (int hh = 1; hh <= MAX_WINDOW / 2; hh++) begin
			if (int'(h) == hh) begin
				n = (2 * hh + 1) * (2 * hh + 1) - 1;
				ctr = hh * (2 * hh + 1) + hh;
				for (int dr = 0; dr <= 2 * hh; dr++) begin
					for (int dc = 0; dc <= 2 * hh; dc++) begin
						pos = (2 * hh - dr) * (2 * hh + 1) + (2 * hh - dc);
						if (pos != ctr) begin
							if (pos > ctr) pos = pos - 1;
							code[n - 1 - pos] = (w[dr][dc] < w[hh][hh]);
						end
					end
				end
			end
		end
		return code;
	endfunction

	always_comb begin
		width_ext = TW'(cfg.image_width);
		col_a = pix.frame_start ? '0 : TW'(col_q);
		row_a = pix.frame_start ? '0 : {1'b0, row_q};
		slot_a = pix.frame_start ? '0 : slot_q;
		if (col_a >= width_ext) begin
			col_a = '0;
			row_a = row_a + 11'd1;
			slot_a = slot_inc(slot_a);
		end
		if (row_a >= cfg.image_height) begin
			row_a = '0;
			slot_a = '0;
		end
		col_n = col_a + TW'(1);
		row_n = row_a;
		slot_n = slot_a;
		if (col_n >= width_ext) begin
			col_n = '0;
			row_n = row_n + 11'd1;
			slot_n = slot_inc(slot_n);
			if (row_n >= cfg.image_height) begin
				row_n = '0;
				slot_n = '0;
			end
		end
	end

	always_comb begin
		for (int k = 1; k <= LINES; k++) begin
			int s;
			s = int'(slot_cur_q) + LINES - k;
			if (s >= LINES) s = s - LINES;
			line_sel[k] = SW'(s);
		end
	end

	assign half = cfg.window_size[2:1];
	assign two_half = {half, 1'b0};
	assign interior = (row_cur_q >= 10'(two_half)) && (col_cur_q >= XW'(two_half));
	assign last = (11'(row_cur_q) + 11'd1 == cfg.image_height)
		&& (TW'(col_cur_q) + TW'(1) == width_ext);
	assign y_val = row_cur_q - 10'(half);
	assign x_val = col_cur_q - XW'(half);
	assign lcode = census(wl_q, half);
	assign rcode = census(wr_q, half);
	assign ent_data = {last, y_val, x_val, rcode, lcode};

	always_comb begin
		state_d = state_q;
		pix.ready = 1'b0;
		ent_valid = 1'b0;
		case (state_q)
			cdsd_pkg::F_IDLE: begin
				pix.ready = 1'b1;
				if (pix.valid) state_d = cdsd_pkg::F_SHIFT;
			end
			cdsd_pkg::F_SHIFT: begin
				state_d = cdsd_pkg::F_PUSH;
			end
			cdsd_pkg::F_PUSH: begin
				ent_valid = interior;
				if (!interior || ent_ready) state_d = cdsd_pkg::F_IDLE;
			end
			default: begin
				state_d = cdsd_pkg::F_IDLE;
			end
		endcase
	end

	assign accept = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdsd_pkg::F_IDLE;
			row_q <= '0;
			col_q <= '0;
			slot_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				row_q <= row_n[9:0];
				col_q <= col_n[XW-1:0];
				slot_q <= slot_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_cur_q <= row_a[9:0];
			col_cur_q <= col_a[XW-1:0];
			slot_cur_q <= slot_a;
			lp_q <= pix.left_pixel;
			rp_q <= pix.right_pixel;
		end
	end

	// Each line is read before it is overwritten, so the oldest line comes out of the
	// same slot that takes the new pixel.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < LINES; k++) begin
				if (slot_a == SW'(k)) begin
					mem_l[k][col_a[XW-1:0]] <= pix.left_pixel;
					mem_r[k][col_a[XW-1:0]] <= pix.right_pixel;
				end
				rdl_q[k] <= mem_l[k][col_a[XW-1:0]];
				rdr_q[k] <= mem_r[k][col_a[XW-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cdsd_pkg::F_SHIFT) begin
			for (int k = 0; k < MAX_WINDOW; k++) begin
				for (int j = 1; j < MAX_WINDOW; j++) begin
					wl_q[k][j] <= wl_q[k][j-1];
					wr_q[k][j] <= wr_q[k][j-1];
				end
			end
			wl_q[0][0] <= lp_q;
			wr_q[0][0] <= rp_q;
			for (int k = 1; k <= LINES; k++) begin
				wl_q[k][0] <= rdl_q[line_sel[k]];
				wr_q[k][0] <= rdr_q[line_sel[k]];
			end
		end
	end

endmodule

// File: sv/cdsd_queue.sv
module cdsd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cdsd_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input logic [WIDTH-1:0] push_data,
	output logic pop_valid,
	input logic pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rp_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (pop) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

// File: sv/cdsd_back.sv
module cdsd_back #(
	parameter int MAX_WIDTH = cdsd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW = cdsd_pkg::MAX_WINDOW_DEF,
	parameter int MAX_DISP = cdsd_pkg::MAX_DISP_DEF,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int CODE_W = MAX_WINDOW * MAX_WINDOW - 1,
	localparam int EW = 2 * CODE_W + XW + 11
) (
	input logic clk,
	input logic arst_n,
	input cdsd_pkg::cdsd_cfg_t cfg,
	input logic ent_valid,
	output logic ent_ready,
	input logic [EW-1:0] ent_data,
	cdsd_out_if.source res
);

	localparam int DW = $clog2(MAX_DISP);
	localparam int HW = DW;
	localparam int HDEPTH = 1 << HW;
	localparam int PW = $clog2(CODE_W + 1);
	localparam int NCH = (CODE_W + 7) / 8;
	localparam int PADW = NCH * 8;
	localparam int KW = ((XW > DW) ? XW : DW) + 1;
	localparam int RW = DW + 9;

	cdsd_pkg::back_state_t state_q, state_d;

	logic [CODE_W-1:0] hist [HDEPTH];

	logic [CODE_W-1:0] e_lc, e_rc;
	logic [XW-1:0] e_x;
	logic [9:0] e_y;
	logic e_last;

	logic [CODE_W-1:0] lc_q;
	logic [XW-1:0] x_q;
	logic [9:0] y_q;
	logic last_q;
	logic [PW-1:0] best_q;
	logic [DW-1:0] bd_q, d_q;

	logic rdv_s1, cand_s1;
	logic [DW-1:0] dd_s1;
	logic [CODE_W-1:0] hist_rd_s1;
	logic [PW-1:0] cost;
	logic improve;
	logic [HW-1:0] rd_addr;

	logic [RW-1:0] rem_q, div_shift;
	logic [7:0] quo_q;
	logic [2:0] bit_q;

	logic res_valid_q;
	logic [9:0] row_o_q, col_o_q;
	logic [6:0] disp_o_q;
	logic [7:0] scaled_o_q;
	logic [5:0] cost_o_q;
	logic last_o_q;
	logic load_out;
	logic [1:0] half;

	function automatic logic [PW-1:0] popcnt(input logic [CODE_W-1:0] v);
		logic [PADW-1:0] pv;
		logic [3:0] part;
		logic [PW-1:0] sum;
		pv = PADW'(v);
		sum = '0;
		for (int i = 0; i < NCH; i++) begin
			part = '0;
			for (int j = 0; j < 8; j++) part = part + 4'(pv[i*8+j]);
			sum = sum + PW'(part);
		end
		return sum;
	endfunction

	assign {e_last, e_y, e_x, e_rc, e_lc} = ent_data;
	assign half = cfg.window_size[2:1];
	assign rd_addr = HW'(x_q) - HW'(d_q);
	assign cost = popcnt(lc_q ^ hist_rd_s1);
	assign improve = rdv_s1 && cand_s1 && (cost < best_q);
	assign div_shift = RW'(cfg.num_disparities) << bit_q;
	assign load_out = !res_valid_q || res.ready;

	always_comb begin
		state_d = state_q;
		ent_ready = 1'b0;
		case (state_q)
			cdsd_pkg::B_IDLE: begin
				ent_ready = 1'b1;
				if (ent_valid) state_d = cdsd_pkg::B_SEARCH;
			end
			cdsd_pkg::B_SEARCH: begin
				if (d_q == DW'(1)) state_d = cdsd_pkg::B_DRAIN;
			end
			cdsd_pkg::B_DRAIN: begin
				state_d = cdsd_pkg::B_DIVSET;
			end
			cdsd_pkg::B_DIVSET: begin
				state_d = cdsd_pkg::B_DIV;
			end
			cdsd_pkg::B_DIV: begin
				if (bit_q == 3'd0) state_d = cdsd_pkg::B_OUT;
			end
			cdsd_pkg::B_OUT: begin
				if (load_out) state_d = cdsd_pkg::B_IDLE;
			end
			default: begin
				state_d = cdsd_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdsd_pkg::B_IDLE;
			rdv_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1 <= (state_q == cdsd_pkg::B_SEARCH);
			if (state_q == cdsd_pkg::B_OUT && load_out) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	// The history takes the right code of every interior pixel; candidates read it one
	// disparity per cycle, from the highest down.
	always_ff @(posedge clk) begin
		if (state_q == cdsd_pkg::B_IDLE && ent_valid) hist[HW'(e_x)] <= e_rc;
		if (state_q == cdsd_pkg::B_SEARCH) hist_rd_s1 <= hist[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cdsd_pkg::B_IDLE: begin
				if (ent_valid) begin
					lc_q <= e_lc;
					x_q <= e_x;
					y_q <= e_y;
					last_q <= e_last;
					best_q <= popcnt(e_lc ^ e_rc);
					bd_q <= '0;
					d_q <= DW'(cfg.num_disparities - 8'd1);
				end
			end
			cdsd_pkg::B_SEARCH: begin
				dd_s1 <= d_q;
				cand_s1 <= (KW'(x_q) >= KW'(half) + KW'(d_q));
				d_q <= d_q - DW'(1);
			end
			cdsd_pkg::B_DIVSET: begin
				rem_q <= (RW'(bd_q) << 8) - RW'(bd_q);
				quo_q <= '0;
				bit_q <= 3'd7;
			end
			cdsd_pkg::B_DIV: begin
				if (rem_q >= div_shift) begin
					rem_q <= rem_q - div_shift;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 3'd1;
			end
			cdsd_pkg::B_OUT: begin
				if (load_out) begin
					row_o_q <= y_q;
					col_o_q <= 10'(x_q);
					disp_o_q <= 7'(bd_q);
					scaled_o_q <= quo_q;
					cost_o_q <= 6'(best_q);
					last_o_q <= last_q;
				end
			end
			default: begin
			end
		endcase
		if (improve && (state_q == cdsd_pkg::B_SEARCH || state_q == cdsd_pkg::B_DRAIN)) begin
			best_q <= cost;
			bd_q <= dd_s1;
		end
	end

	assign res.valid = res_valid_q;
	assign res.pixel_row = row_o_q;
	assign res.pixel_column = col_o_q;
	assign res.disparity = disp_o_q;
	assign res.scaled_disparity = scaled_o_q;
	assign res.best_cost = cost_o_q;
	assign res.frame_last = last_o_q;

endmodule

// File: tb/tb.sv
module tb;

	localparam int LINE_CNT = cdsd_pkg::MAX_WINDOW_DEF - 1;
	localparam int STALL_LIMIT = 20000;

	typedef logic [7:0] pix_win_t [0:cdsd_pkg::MAX_WINDOW_DEF-1][0:cdsd_pkg::MAX_WINDOW_DEF-1];

	typedef struct {
		logic [7:0] left_pixel;
		logic [7:0] right_pixel;
		logic frame_start;
		logic hold;
	} pixel_pair_t;

	typedef struct {
		logic [9:0] pixel_row;
		logic [9:0] pixel_column;
		logic [6:0] disparity;
		logic [7:0] scaled_disparity;
		logic [5:0] best_cost;
		logic frame_last;
	} disp_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	cdsd_in_if pix_if();
	cdsd_out_if res_if();

	census_stereo_disparity_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix(pix_if), .res(res_if)
	);

	pixel_pair_t pending_pixels[$];
	disp_result_t expected_disp[$];
	int errors = 0;
	int pixels_in = 0;
	int results_out = 0;
	int phases_run = 0;
	int quiet_cycles = 0;
	logic pix_taken = 0;

	// Matcher copy: configuration, counters, line stores, windows and code history.
	int unsigned win_sz, n_disp, img_w, img_h;
	int unsigned row_cnt, col_cnt;
	logic [7:0] left_lines [0:LINE_CNT*cdsd_pkg::MAX_WIDTH_DEF-1];
	logic [7:0] right_lines [0:LINE_CNT*cdsd_pkg::MAX_WIDTH_DEF-1];
	pix_win_t left_win, right_win;
	logic [47:0] right_codes [0:cdsd_pkg::MAX_DISP_DEF-1];

	function automatic int unsigned ones48(logic [47:0] v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 48; i++)
			n += v[i];
		return n;
	endfunction

	function automatic logic [47:0] census_code(pix_win_t w, int unsigned h);
		logic [47:0] code;
		logic [7:0] ctr;
		code = '0;
		ctr = w[h][h];
		for (int dr = 2*h; dr >= 0; dr--)
			for (int dc = 2*h; dc >= 0; dc--) begin
				if (dr == h && dc == h)
					continue;
				code = {code[46:0], w[dr][dc] < ctr};
			end
		return code;
	endfunction

	task automatic set_register(logic [1:0] idx, logic [31:0] value);
		int unsigned v;
		case (idx)
			cdsd_pkg::REG_WINDOW: begin
				v = value & 7;
				if (v % 2 == 0) v++;
				if (v < 3) v = 3;
				if (v > ((cdsd_pkg::MAX_WINDOW_DEF - 1) | 1))
					v = (cdsd_pkg::MAX_WINDOW_DEF - 1) | 1;
				win_sz = v;
			end
			cdsd_pkg::REG_DISP: begin
				v = ((value & 'hFF) / 16) * 16;
				if (v < 16) v = 16;
				if (v > cdsd_pkg::MAX_DISP_DEF) v = cdsd_pkg::MAX_DISP_DEF;
				n_disp = v;
			end
			cdsd_pkg::REG_WIDTH: begin
				v = value & 'h7FF;
				if (v < 8) v = 8;
				if (v > cdsd_pkg::MAX_WIDTH_DEF) v = cdsd_pkg::MAX_WIDTH_DEF;
				img_w = v;
			end
			default: begin
				v = value & 'h7FF;
				if (v < 8) v = 8;
				if (v > cdsd_pkg::HEIGHT_TOP) v = cdsd_pkg::HEIGHT_TOP;
				img_h = v;
			end
		endcase
	endtask

	task automatic predict_disparity(logic [7:0] lp, logic [7:0] rp, logic fs);
		int unsigned r, c, h, slot, x, y, best, bd, cost;
		logic [47:0] lc, rc;
		disp_result_t res;
		if (fs) begin
			row_cnt = 0;
			col_cnt = 0;
		end
		if (col_cnt >= img_w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= img_h)
			row_cnt = 0;
		r = row_cnt;
		c = col_cnt;
		for (int k = 0; k < cdsd_pkg::MAX_WINDOW_DEF; k++)
			for (int j = cdsd_pkg::MAX_WINDOW_DEF - 1; j > 0; j--) begin
				left_win[k][j] = left_win[k][j-1];
				right_win[k][j] = right_win[k][j-1];
			end
		left_win[0][0] = lp;
		right_win[0][0] = rp;
		for (int k = 1; k <= LINE_CNT; k++) begin
			slot = ((r % LINE_CNT) + LINE_CNT - k) % LINE_CNT;
			left_win[k][0] = left_lines[slot*cdsd_pkg::MAX_WIDTH_DEF + c];
			right_win[k][0] = right_lines[slot*cdsd_pkg::MAX_WIDTH_DEF + c];
		end
		slot = r % LINE_CNT;
		left_lines[slot*cdsd_pkg::MAX_WIDTH_DEF + c] = lp;
		right_lines[slot*cdsd_pkg::MAX_WIDTH_DEF + c] = rp;
		h = win_sz / 2;
		if (r >= 2*h && c >= 2*h) begin
			x = c - h;
			y = r - h;
			lc = census_code(left_win, h);
			rc = census_code(right_win, h);
			right_codes[x % cdsd_pkg::MAX_DISP_DEF] = rc;
			best = ones48(lc ^ rc);
			bd = 0;
			// d = 0 first, then highest d down; only a strictly lower cost wins.
			for (int d = n_disp - 1; d >= 1; d--) begin
				if (x < h + d)
					continue;
				cost = ones48(lc ^ right_codes[(x - d) % cdsd_pkg::MAX_DISP_DEF]);
				if (cost < best) begin
					best = cost;
					bd = d;
				end
			end
			res.pixel_row = 10'(y);
			res.pixel_column = 10'(x);
			res.disparity = 7'(bd);
			res.scaled_disparity = 8'((bd * 255) / n_disp);
			res.best_cost = 6'(best);
			res.frame_last = (r + 1 == img_h && c + 1 == img_w);
			expected_disp.push_back(res);
		end
		col_cnt++;
		if (col_cnt >= img_w) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= img_h)
				row_cnt = 0;
		end
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Input sampling, prediction and result checking.
	always @(posedge clk) begin
		if (arst_n) begin
			pix_taken <= pix_if.valid && pix_if.ready;
			if (pix_if.valid && pix_if.ready) begin
				predict_disparity(pix_if.left_pixel, pix_if.right_pixel, pix_if.frame_start);
				pixels_in++;
			end
			if (res_if.valid && res_if.ready) begin
				results_out++;
				if (expected_disp.size() == 0) begin
					$error("result item with nothing expected: row %0d col %0d",
						res_if.pixel_row, res_if.pixel_column);
					errors++;
				end else begin
					disp_result_t e;
					e = expected_disp.pop_front();
					if (res_if.pixel_row !== e.pixel_row) begin
						$error("pixel_row: expected %0d, got %0d", e.pixel_row, res_if.pixel_row);
						errors++;
					end
					if (res_if.pixel_column !== e.pixel_column) begin
						$error("pixel_column: expected %0d, got %0d", e.pixel_column,
							res_if.pixel_column);
						errors++;
					end
					if (res_if.disparity !== e.disparity) begin
						$error("disparity: expected %0d, got %0d", e.disparity, res_if.disparity);
						errors++;
					end
					if (res_if.scaled_disparity !== e.scaled_disparity) begin
						$error("scaled_disparity: expected %0d, got %0d", e.scaled_disparity,
							res_if.scaled_disparity);
						errors++;
					end
					if (res_if.best_cost !== e.best_cost) begin
						$error("best_cost: expected %0d, got %0d", e.best_cost, res_if.best_cost);
						errors++;
					end
					if (res_if.frame_last !== e.frame_last) begin
						$error("frame_last: expected %0d, got %0d", e.frame_last,
							res_if.frame_last);
						errors++;
					end
				end
			end
		end
	end

	// Sender: bursts of items separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		pixel_pair_t it;
		logic nv;
		nv = pix_if.valid;
		if (arst_n && (!pix_if.valid || pix_taken)) begin
			nv = 0;
			if (gap_left > 0)
				gap_left--;
			else if (pending_pixels.size() > 0 &&
					(!pending_pixels[0].hold || expected_disp.size() == 0)) begin
				it = pending_pixels.pop_front();
				nv = 1;
				pix_if.left_pixel <= it.left_pixel;
				pix_if.right_pixel <= it.right_pixel;
				pix_if.frame_start <= it.frame_start;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(1, 60);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		pix_if.valid <= nv;
	end

	// Receiver: segments of always ready, coin flips, and a duty-cycle pattern.
	int seg_left = 0;
	int seg_mode = 0;
	int seg_pos = 0;
	always @(negedge clk) begin
		if (seg_left == 0) begin
			seg_left = $urandom_range(1, 80);
			seg_mode = $urandom_range(0, 2);
			seg_pos = 0;
		end
		seg_left--;
		seg_pos++;
		case (seg_mode)
			0: res_if.ready <= 1'b1;
			1: res_if.ready <= 1'($urandom_range(0, 1));
			default: res_if.ready <= (seg_pos % 8) >= 5;
		endcase
	end

	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d results still expected", expected_disp.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		do
			@(posedge clk);
		while (!pready);
		set_register(idx, value);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() > 0 || pix_if.valid || expected_disp.size() > 0)
			@(posedge clk);
		// The front end may still hold border pixels that give no result.
		repeat (60) @(posedge clk);
	endtask

	// Textured rows where the right image is the left one shifted by a random disparity.
	logic [7:0] texture [0:2047];
	task automatic queue_pixels(int rows, bit directed);
		pixel_pair_t p;
		int gr, gc, shift, mode, n;
		gr = 0;
		gc = 0;
		n = 0;
		shift = $urandom_range(0, n_disp - 1);
		mode = $urandom_range(0, 3);
		for (int i = 0; i < 2048; i++)
			texture[i] = (mode == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) :
				(mode == 1) ? 8'(100 + $urandom_range(0, 6)) : 8'($urandom);
		while (n < rows * img_w) begin
			p.frame_start = (n == 0);
			p.hold = (n == rows * img_w / 2);
			if (n > 0 && $urandom_range(0, 399) == 0) begin
				p.frame_start = 1;
				gr = 0;
				gc = 0;
			end
			p.left_pixel = texture[(gr*37 + gc) % 2048];
			p.right_pixel = texture[(gr*37 + gc + shift) % 2048];
			if ($urandom_range(0, 19) == 0)
				p.right_pixel = 8'($urandom);
			if (directed && n < 24) begin
				p.left_pixel = (n % 3 == 0) ? 8'h00 : (n % 3 == 1) ? 8'hFF : 8'(n * 11);
				p.right_pixel = (n % 2) ? 8'h00 : 8'hFF;
			end
			pending_pixels.push_back(p);
			n++;
			gc++;
			if (gc >= img_w) begin
				gc = 0;
				gr++;
			end
		end
	endtask

	task automatic run_phase(logic [31:0] ws, logic [31:0] nd, logic [31:0] w, logic [31:0] h,
			int rows, bit directed);
		wait_idle();
		apb_write(cdsd_pkg::REG_WINDOW, ws);
		apb_write(cdsd_pkg::REG_DISP, nd);
		apb_write(cdsd_pkg::REG_WIDTH, w);
		apb_write(cdsd_pkg::REG_HEIGHT, h);
		queue_pixels(rows, directed);
		phases_run++;
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		pix_if.valid = 0;
		pix_if.left_pixel = '0;
		pix_if.right_pixel = '0;
		pix_if.frame_start = 0;
		res_if.ready = 0;
		win_sz = 32'(cdsd_pkg::WINDOW_RESET);
		n_disp = 32'(cdsd_pkg::DISP_RESET);
		img_w = 32'(cdsd_pkg::WIDTH_RESET);
		img_h = 32'(cdsd_pkg::HEIGHT_RESET);
		row_cnt = 0;
		col_cnt = 0;
		for (int i = 0; i < LINE_CNT*cdsd_pkg::MAX_WIDTH_DEF; i++) begin
			left_lines[i] = '0;
			right_lines[i] = '0;
		end
		for (int k = 0; k < cdsd_pkg::MAX_WINDOW_DEF; k++)
			for (int j = 0; j < cdsd_pkg::MAX_WINDOW_DEF; j++) begin
				left_win[k][j] = '0;
				right_win[k][j] = '0;
			end
		for (int i = 0; i < cdsd_pkg::MAX_DISP_DEF; i++)
			right_codes[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Rounding and saturation of every register, then the extremes of size and window.
		run_phase(2, 15, 3, 0, 8, 1);
		run_phase(7, 200, 40, 12, 9, 0);
		run_phase(4, 64, 24, 10, 10, 0);
		run_phase(6, 48, 17, 9, 10, 0);
		run_phase(3, 16, 200, 1024, 3, 0);
		run_phase('hD, 'h1F0, 'h814, 'h80B, 10, 0);
		while (pixels_in + pending_pixels.size() < 1800)
			run_phase($urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 30),
				$urandom_range(6, 12), $urandom_range(8, 24), 0);

		while (pending_pixels.size() > 0 || pix_if.valid || expected_disp.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d configuration phases, %0d pixel pairs sent, %0d disparity results checked",
			phases_run, pixels_in, results_out);
		if (errors == 0 && expected_disp.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
sv/cdsd_pkg.sv
sv/cdsd_in_if.sv
sv/cdsd_out_if.sv
sv/cdsd_front.sv
sv/cdsd_queue.sv
sv/cdsd_back.sv
sv/census_stereo_disparity_top.sv
tb/tb.sv
